[design/tbb_pkg.sv]
// Shared types, widths and reset constants for the transformed bounding box block.
package tbb_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int CFG_IDX_W = 3;

    // Exact product, sum, rounded and offset widths of one transform row.
    localparam int PROD_W    = COEF_W + COORD_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_SH   = 12;
    localparam int RND_W     = ACC_W - FRAC_SH;
    localparam int SUM_W     = RND_W + 1;

    // Half of one Q16.16 step in the Q22.28 sum, used for rounding.
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);

    // Saturation limits for a Q16.16 coordinate.
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    // Register reset values; the three rows form the identity (1.0 in Q4.12).
    localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X    = 3'd0,
        REG_ROW_Y    = 3'd1,
        REG_ROW_Z    = 3'd2,
        REG_OFFSET_X = 3'd3,
        REG_OFFSET_Y = 3'd4,
        REG_OFFSET_Z = 3'd5
    } t_cfg_reg;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [ROW_W-1:0] row_x;
        logic [ROW_W-1:0] row_y;
        logic [ROW_W-1:0] row_z;
        t_coord           offset_x;
        t_coord           offset_y;
        t_coord           offset_z;
    } t_cfg;

endpackage

[design/tbb_intf.sv]
// Channel interfaces: vertex requests in, box results out, and register writes.
interface tbb_vertex_if import tbb_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   start_box;
    t_coord x_in;
    t_coord y_in;
    t_coord z_in;

    modport source (output valid, start_box, x_in, y_in, z_in, input ready);
    modport sink   (input valid, start_box, x_in, y_in, z_in, output ready);
endinterface

interface tbb_box_if import tbb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord min_x_out;
    t_coord min_y_out;
    t_coord min_z_out;
    t_coord max_x_out;
    t_coord max_y_out;
    t_coord max_z_out;

    modport source (output valid, min_x_out, min_y_out, min_z_out,
                    max_x_out, max_y_out, max_z_out, input ready);
    modport sink   (input valid, min_x_out, min_y_out, min_z_out,
                    max_x_out, max_y_out, max_z_out, output ready);
endinterface

interface tbb_cfg_if import tbb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/transform_bounding_box.sv]
// Top level: affine transform of each vertex and a running axis-aligned box.
//
//   Channel    Role    Request payload
//   i_vertex   sink    start_box, x_in, y_in, z_in (Q16.16)
//   o_box      source  min_x/y/z_out, max_x/y/z_out (Q16.16)
//   i_cfg      sink    index (3 bits), data (48 bits); always ready
//
// A vertex is accepted every cycle while the vertex register is empty or moves on.
// The vertex register feeds the nine multipliers, the row adders and the
// min/max compare combinationally, and the box registers are the result register.
// Reset loads the identity transform, zero offsets and an empty box at the origin.
// A stalled result holds the box; the vertex register still takes one request.
module transform_bounding_box import tbb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbb_vertex_if.sink  i_vertex,
    tbb_box_if.source   o_box,
    tbb_cfg_if.sink     i_cfg
);

    t_cfg   cfg;
    logic   r_s1_valid;
    logic   r_s1_start;
    t_coord r_s1_x;
    t_coord r_s1_y;
    t_coord r_s1_z;
    logic   r_out_valid;
    logic   out_free;
    logic   s1_fire;
    logic   in_fire;
    t_coord tx;
    t_coord ty;
    t_coord tz;

    // Register file.
    tbb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Handshake: the vertex register moves on when the result register is free.
    assign out_free       = !r_out_valid || o_box.ready;
    assign s1_fire        = r_s1_valid && out_free;
    assign i_vertex.ready = !r_s1_valid || out_free;
    assign in_fire        = i_vertex.valid && i_vertex.ready;

    // Vertex register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_vertex.ready) begin
            r_s1_valid <= i_vertex.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_start <= i_vertex.start_box;
            r_s1_x     <= i_vertex.x_in;
            r_s1_y     <= i_vertex.y_in;
            r_s1_z     <= i_vertex.z_in;
        end
    end

    // Transform rows.
    tbb_row_xform u_row_x (
        .i_row (cfg.row_x), .i_offset (cfg.offset_x),
        .i_x (r_s1_x), .i_y (r_s1_y), .i_z (r_s1_z), .o_coord (tx)
    );
    tbb_row_xform u_row_y (
        .i_row (cfg.row_y), .i_offset (cfg.offset_y),
        .i_x (r_s1_x), .i_y (r_s1_y), .i_z (r_s1_z), .o_coord (ty)
    );
    tbb_row_xform u_row_z (
        .i_row (cfg.row_z), .i_offset (cfg.offset_z),
        .i_x (r_s1_x), .i_y (r_s1_y), .i_z (r_s1_z), .o_coord (tz)
    );

    // Box registers, one pair per axis; they also carry the result.
    tbb_axis_bound u_bound_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s1_fire), .i_clear (r_s1_start),
        .i_coord (tx), .o_lo (o_box.min_x_out), .o_hi (o_box.max_x_out)
    );
    tbb_axis_bound u_bound_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s1_fire), .i_clear (r_s1_start),
        .i_coord (ty), .o_lo (o_box.min_y_out), .o_hi (o_box.max_y_out)
    );
    tbb_axis_bound u_bound_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (s1_fire), .i_clear (r_s1_start),
        .i_coord (tz), .o_lo (o_box.min_z_out), .o_hi (o_box.max_z_out)
    );

    // Result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_box.valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // The box always contains the origin.
    a_origin_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.min_x_out <= 32'sd0 && o_box.max_x_out >= 32'sd0 &&
        o_box.min_y_out <= 32'sd0 && o_box.max_y_out >= 32'sd0 &&
        o_box.min_z_out <= 32'sd0 && o_box.max_z_out >= 32'sd0)
        else $error("box does not contain the origin");

    // Minimum never passes maximum on any axis.
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_box.min_x_out <= o_box.max_x_out &&
        o_box.min_y_out <= o_box.max_y_out &&
        o_box.min_z_out <= o_box.max_z_out)
        else $error("box minimum exceeds maximum");

    // The box changes only when a vertex moves into the result register.
    a_box_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(o_box.min_x_out) && $stable(o_box.max_x_out) &&
                     $stable(o_box.min_y_out) && $stable(o_box.max_y_out) &&
                     $stable(o_box.min_z_out) && $stable(o_box.max_z_out))
        else $error("box changed without a vertex");

    // Every vertex that leaves the vertex register yields a result.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> r_out_valid)
        else $error("processed vertex produced no result");
`endif

endmodule

[design/tbb_cfg_regs.sv]
// Configuration register file: three coefficient rows and three offsets.
module tbb_cfg_regs import tbb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbb_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; indexes past the list are dropped.
    assign i_cfg.ready = 1'b1;

    // Decode the register index of a write request.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROW_X:    n_cfg.row_x    = i_cfg.data;
                REG_ROW_Y:    n_cfg.row_y    = i_cfg.data;
                REG_ROW_Z:    n_cfg.row_z    = i_cfg.data;
                REG_OFFSET_X: n_cfg.offset_x = i_cfg.data[COORD_W-1:0];
                REG_OFFSET_Y: n_cfg.offset_y = i_cfg.data[COORD_W-1:0];
                REG_OFFSET_Z: n_cfg.offset_z = i_cfg.data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_x    <= ROW_X_RESET;
            r_cfg.row_y    <= ROW_Y_RESET;
            r_cfg.row_z    <= ROW_Z_RESET;
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
            r_cfg.offset_z <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/tbb_row_xform.sv]
// One row of the affine transform: dot product, rounding, offset and saturation.
module tbb_row_xform import tbb_pkg::*; (
    input  logic [ROW_W-1:0] i_row,
    input  t_coord           i_offset,
    input  t_coord           i_x,
    input  t_coord           i_y,
    input  t_coord           i_z,
    output t_coord           o_coord
);

    logic signed [COEF_W-1:0] coef_x;
    logic signed [COEF_W-1:0] coef_y;
    logic signed [COEF_W-1:0] coef_z;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  biased;
    logic signed [RND_W-1:0]  rounded;
    logic signed [SUM_W-1:0]  shifted;

    // Unpack the Q4.12 coefficients.
    assign coef_x = i_row[COEF_W-1:0];
    assign coef_y = i_row[2*COEF_W-1:COEF_W];
    assign coef_z = i_row[3*COEF_W-1:2*COEF_W];

    // Exact Q20.28 products and their sum.
    assign prod_x = coef_x * i_x;
    assign prod_y = coef_y * i_y;
    assign prod_z = coef_z * i_z;
    assign acc    = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z);

    // Round half up to Q16.16 with an arithmetic shift, then add the offset.
    assign biased  = acc + ROUND_HALF;
    assign rounded = biased[ACC_W-1:FRAC_SH];
    assign shifted = SUM_W'(rounded) + SUM_W'(i_offset);

    // Clamp to the signed 32-bit range when the upper bits disagree.
    always_comb begin
        if (!shifted[SUM_W-1] && (|shifted[SUM_W-2:COORD_W-1])) begin
            o_coord = COORD_MAX;
        end else if (shifted[SUM_W-1] && !(&shifted[SUM_W-2:COORD_W-1])) begin
            o_coord = COORD_MIN;
        end else begin
            o_coord = shifted[COORD_W-1:0];
        end
    end

endmodule

[design/tbb_axis_bound.sv]
// Running minimum and maximum of one axis, cleared on a start request.
module tbb_axis_bound import tbb_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_clear,
    input  t_coord i_coord,
    output t_coord o_lo,
    output t_coord o_hi
);

    t_coord r_lo;
    t_coord r_hi;
    t_coord n_lo;
    t_coord n_hi;
    t_coord base_lo;
    t_coord base_hi;

    // A start request widens from an empty box at the origin.
    assign base_lo = i_clear ? '0 : r_lo;
    assign base_hi = i_clear ? '0 : r_hi;

    // Ties keep the current bound.
    assign n_lo = (i_coord < base_lo) ? i_coord : base_lo;
    assign n_hi = (i_coord > base_hi) ? i_coord : base_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

[tb/box_checker.sv]
// Box result checker: follows the register and vertex channels, predicts each box and compares.
module box_checker import tbb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tbb_vertex_if i_vertex,
    tbb_box_if    i_box,
    tbb_cfg_if    i_cfg,
    input  logic  i_wrap_up,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_boxes_seen
);

    // Rounding bias of one Q16.16 step in the Q22.28 sum.
    localparam longint HALF_LSB     = 2048;
    localparam int     REPORT_LINES = 30;

    typedef struct packed {
        t_coord lo_x, lo_y, lo_z;
        t_coord hi_x, hi_y, hi_z;
    } t_box;

    // Local copy of the transform registers and of the running box.
    logic [ROW_W-1:0] row_x, row_y, row_z;
    t_coord           off_x, off_y, off_z;
    t_box             running_box;
    t_box             expected_boxes[$];
    int               fail_count  = 0;
    int               boxes_seen  = 0;
    bit               wrapped     = 1'b0;

    assign o_fail_count = fail_count;
    assign o_boxes_seen = boxes_seen;

    // Print one line for a failure and count it; printing stops after a while.
    task automatic report(input string what);
        fail_count++;
        if (fail_count <= REPORT_LINES) begin
            $display("box %0d: %s", boxes_seen, what);
        end
    endtask

    task automatic check_field(input string name, input t_coord got, input t_coord want);
        if (got !== want) begin
            report($sformatf("%s got %h, expected %h", name, got, want));
        end
    endtask

    // One output axis: exact sum of three products, round half up to Q16.16,
    // add the offset and clamp to the signed 32-bit range.
    function automatic t_coord transform_axis(input logic [ROW_W-1:0] row, input t_coord off,
                                              input t_coord x, input t_coord y,
                                              input t_coord z);
        longint acc;
        longint sum;
        acc = longint'($signed(row[COEF_W-1:0])) * longint'(x)
            + longint'($signed(row[2*COEF_W-1:COEF_W])) * longint'(y)
            + longint'($signed(row[3*COEF_W-1:2*COEF_W])) * longint'(z);
        sum = ((acc + HALF_LSB) >>> FRAC_SH) + longint'(off);
        if (sum > longint'(COORD_MAX)) sum = longint'(COORD_MAX);
        if (sum < longint'(COORD_MIN)) sum = longint'(COORD_MIN);
        return t_coord'(sum);
    endfunction

    // A coordinate equal to a bound leaves it alone.
    task automatic widen(inout t_coord lo, inout t_coord hi, input t_coord v);
        if (v > hi) hi = v;
        if (v < lo) lo = v;
    endtask

    always @(posedge i_clk) begin
        t_box   got;
        t_box   want;
        t_coord tx, ty, tz;
        if (!i_rst_n) begin
            row_x       = ROW_X_RESET;
            row_y       = ROW_Y_RESET;
            row_z       = ROW_Z_RESET;
            off_x       = '0;
            off_y       = '0;
            off_z       = '0;
            running_box = '0;
            expected_boxes.delete();
        end else begin
            // Box result: compare with the oldest prediction.
            if (i_box.valid && i_box.ready) begin
                boxes_seen++;
                got = '{i_box.min_x_out, i_box.min_y_out, i_box.min_z_out,
                        i_box.max_x_out, i_box.max_y_out, i_box.max_z_out};
                if (expected_boxes.size() == 0) begin
                    report("box result with no vertex request waiting");
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("min_x", got.lo_x, want.lo_x);
                    check_field("min_y", got.lo_y, want.lo_y);
                    check_field("min_z", got.lo_z, want.lo_z);
                    check_field("max_x", got.hi_x, want.hi_x);
                    check_field("max_y", got.hi_y, want.hi_y);
                    check_field("max_z", got.hi_z, want.hi_z);
                end
            end

            // Register write; indexes past the offsets are ignored.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ROW_X:    row_x = i_cfg.data;
                    REG_ROW_Y:    row_y = i_cfg.data;
                    REG_ROW_Z:    row_z = i_cfg.data;
                    REG_OFFSET_X: off_x = i_cfg.data[COORD_W-1:0];
                    REG_OFFSET_Y: off_y = i_cfg.data[COORD_W-1:0];
                    REG_OFFSET_Z: off_z = i_cfg.data[COORD_W-1:0];
                    default: ;
                endcase
            end

            // Vertex request: restart the box if asked, then widen it.
            if (i_vertex.valid && i_vertex.ready) begin
                if (i_vertex.start_box) running_box = '0;
                tx = transform_axis(row_x, off_x, i_vertex.x_in, i_vertex.y_in, i_vertex.z_in);
                ty = transform_axis(row_y, off_y, i_vertex.x_in, i_vertex.y_in, i_vertex.z_in);
                tz = transform_axis(row_z, off_z, i_vertex.x_in, i_vertex.y_in, i_vertex.z_in);
                widen(running_box.lo_x, running_box.hi_x, tx);
                widen(running_box.lo_y, running_box.hi_y, ty);
                widen(running_box.lo_z, running_box.hi_z, tz);
                expected_boxes.push_back(running_box);
            end

            // At the end of the run nothing may still be outstanding.
            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (expected_boxes.size() != 0) begin
                    report($sformatf("%0d box results never arrived", expected_boxes.size()));
                end
            end
        end
        o_pending <= expected_boxes.size();
    end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, vertex and register stimulus, result back-pressure and verdict.
module testbench;
    import tbb_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 4;
    localparam int MAX_WAIT        = 14;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_CYCLES     = 200;
    localparam int RUSH_ITEMS      = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int END_LIMIT       = 1000;
    localparam int TIME_LIMIT      = 4_000_000;

    // Register indexes that the block has no register for.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // Q4.12 coefficient values of interest.
    localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7FFF;
    localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;
    localparam logic [COEF_W-1:0] COEF_ONE     = 16'h1000;
    localparam logic [COEF_W-1:0] COEF_HALF    = 16'h0800;
    localparam logic [COEF_W-1:0] COEF_NHALF   = 16'hF800;
    localparam logic [COEF_W-1:0] COEF_LSB     = 16'h0001;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic wrap_up;
    bit   hold_req = 1'b0;
    int   fail_count, pending, boxes_seen;
    int   vertices_sent   = 0;
    int   settings_loaded = 0;
    int   send_run_left   = 0;
    bit   send_calm       = 1'b0;

    tbb_vertex_if vtx ();
    tbb_box_if    box ();
    tbb_cfg_if    cfg ();

    transform_bounding_box i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_vertex (vtx),
        .o_box    (box),
        .i_cfg    (cfg)
    );

    box_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_vertex     (vtx),
        .i_box        (box),
        .i_cfg        (cfg),
        .i_wrap_up    (wrap_up),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_boxes_seen (boxes_seen)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #TIME_LIMIT;
        $display("timeout: run did not finish");
        $display("status: fail");
        $finish;
    end

    // Draw the wait before one request; each run of requests has either random
    // waits or, less often, no waits at all.
    task automatic draw_wait(inout int run_left, inout bit calm, output int gap);
        if (run_left == 0) begin
            run_left = $urandom_range(20, 80);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0:       return COEF_POS_MAX;
            1:       return COEF_NEG_MAX;
            2:       return COEF_ONE;
            3:       return '0;
            4:       return COEF_W'($urandom_range(0, 8191)) - COEF_ONE;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic t_coord pick_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3, 4:    return t_coord'($urandom_range(0, 32'h0010_0000)) - t_coord'(32'h0008_0000);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // Offer one vertex request and hold it until it is taken.
    task automatic push_vertex(input bit rush, input logic start, input t_coord x,
                               input t_coord y, input t_coord z);
        int gap;
        if (rush) gap = 0;
        else draw_wait(send_run_left, send_calm, gap);
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vtx.valid     <= 1'b1;
        vtx.start_box <= start;
        vtx.x_in      <= x;
        vtx.y_in      <= y;
        vtx.z_in      <= z;
        @(posedge clk);
        while (!(vtx.valid && vtx.ready)) @(posedge clk);
        @(negedge clk);
        vertices_sent++;
    endtask

    // Stop offering vertices and wait until every box result is back.
    task automatic drain();
        vtx.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!(cfg.valid && cfg.ready)) @(posedge clk);
        @(negedge clk);
    endtask

    // Load a full setting while idle; offsets carry junk in the unused upper
    // bits, and the spare indexes get junk writes that must change nothing.
    task automatic load_config(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                               input logic [ROW_W-1:0] rz, input t_coord ox,
                               input t_coord oy, input t_coord oz);
        drain();
        write_reg(REG_ROW_X, rx);
        write_reg(REG_SPARE_A, ROW_W'({$urandom, $urandom}));
        write_reg(REG_ROW_Y, ry);
        write_reg(REG_ROW_Z, rz);
        write_reg(REG_OFFSET_X, {COEF_W'($urandom), ox});
        write_reg(REG_SPARE_B, ROW_W'({$urandom, $urandom}));
        write_reg(REG_OFFSET_Y, {COEF_W'($urandom), oy});
        write_reg(REG_OFFSET_Z, {COEF_W'($urandom), oz});
        cfg.valid <= 1'b0;
        settings_loaded++;
    endtask

    // Result side: a random stall before each result, or one long hold-off
    // when the stimulus asks for it.
    initial begin
        int gap;
        int run_left;
        bit calm;
        run_left = 0;
        calm     = 1'b0;
        box.ready <= 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                box.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                box.ready <= 1'b1;
            end else begin
                draw_wait(run_left, calm, gap);
                if (gap > 0) begin
                    box.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                box.ready <= 1'b1;
            end
            @(posedge clk);
            while (!(box.valid && box.ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        int waited;
        logic [ROW_W-1:0] rx, ry, rz;
        t_coord ox, oy, oz;
        vtx.valid     <= 1'b0;
        vtx.start_box <= 1'b0;
        vtx.x_in      <= '0;
        vtx.y_in      <= '0;
        vtx.z_in      <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= '0;
        cfg.data      <= '0;
        wrap_up       <= 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Identity transform from reset: extremes, ties and box restarts.
        push_vertex(1'b0, 1'b1, '0, '0, '0);
        push_vertex(1'b0, 1'b0, COORD_MAX, COORD_MIN, 32'sd1);
        push_vertex(1'b0, 1'b0, COORD_MIN, COORD_MAX, -32'sd1);
        push_vertex(1'b0, 1'b0, COORD_MAX, COORD_MIN, 32'sd1);
        push_vertex(1'b0, 1'b1, 32'sd5, -32'sd5, 32'sd7);
        push_vertex(1'b0, 1'b0, 32'sd5, -32'sd5, 32'sd7);
        push_vertex(1'b0, 1'b0, -32'sd5, 32'sd5, -32'sd7);

        // Extreme coefficients and offsets drive saturation; the z row checks
        // rounding of half steps on either side of zero.
        load_config({3{COEF_POS_MAX}}, {3{COEF_NEG_MAX}}, {COEF_NHALF, COEF_HALF, COEF_LSB},
                    COORD_MAX, COORD_MIN, '0);
        push_vertex(1'b0, 1'b1, COORD_MAX, COORD_MAX, COORD_MAX);
        push_vertex(1'b0, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN);
        push_vertex(1'b0, 1'b1, 32'sd2048, '0, '0);
        push_vertex(1'b0, 1'b0, -32'sd2048, '0, '0);
        push_vertex(1'b0, 1'b0, -32'sd2049, '0, '0);
        push_vertex(1'b0, 1'b0, 32'sd2047, '0, '0);
        push_vertex(1'b0, 1'b1, '0, 32'sd2048, '0);
        push_vertex(1'b0, 1'b0, '0, 32'sd1, 32'sd1);
        push_vertex(1'b0, 1'b1, '0, '0, '0);

        // Random phases, each with its own setting; the first two are the extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    rx = {3{COEF_POS_MAX}};
                    ry = rx;
                    rz = rx;
                    ox = COORD_MAX;
                    oy = COORD_MAX;
                    oz = COORD_MAX;
                end
                1: begin
                    rx = {3{COEF_NEG_MAX}};
                    ry = rx;
                    rz = rx;
                    ox = COORD_MIN;
                    oy = COORD_MIN;
                    oz = COORD_MIN;
                end
                default: begin
                    rx = {pick_coef(), pick_coef(), pick_coef()};
                    ry = {pick_coef(), pick_coef(), pick_coef()};
                    rz = {pick_coef(), pick_coef(), pick_coef()};
                    ox = pick_coord();
                    oy = pick_coord();
                    oz = pick_coord();
                end
            endcase
            load_config(rx, ry, rz, ox, oy, oz);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Back-to-back requests against a long result stall fill the block.
                if (phase == 2 && n == 50) begin
                    hold_req = 1'b1;
                    for (int k = 0; k < RUSH_ITEMS; k++) begin
                        push_vertex(1'b1, $urandom_range(0, 15) == 0,
                                    pick_coord(), pick_coord(), pick_coord());
                    end
                end
                // Let the pipeline run dry in the middle of a phase.
                if (phase == 4 && n == 100) drain();
                push_vertex(1'b0, $urandom_range(0, 15) == 0,
                            pick_coord(), pick_coord(), pick_coord());
            end
        end

        // Wait for the last results, bounded, then let the checker close out.
        vtx.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < END_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(negedge clk);

        $display("covered %0d vertex requests and %0d box results over %0d register settings",
                 vertices_sent, boxes_seen, settings_loaded);
        $display("including saturation, ties, box restarts, a long result stall and a drain");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
